@@ rtl/bss_pkg.sv @@
// Shared types, constants and register map for the bounded substring search block.
`default_nettype none

package bss_pkg;

  // Default geometry
  localparam int QUERY_MAX_DEF   = 16;
  localparam int LIMIT_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int TEXT_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int INDEX_W     = 16;
  localparam int QLEN_W      = 5;
  localparam int LIMIT_REG_W = 16;
  localparam int QUERY_W     = 128;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 5;
  localparam int REG_IDX_W   = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_SEARCHING = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IDLE      = 2'd3;

  // Register indexes (byte address = 8 * index)
  localparam logic [REG_IDX_W-1:0] REG_QUERY_LOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_QUERY_HIGH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUERY_LEN  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT      = 2'd3;

  // Configuration as seen by the match logic
  typedef struct packed {
    logic [QUERY_W-1:0]     query;
    logic [QLEN_W-1:0]      qlen;
    logic [LIMIT_REG_W-1:0] limit;
  } bss_cfg_t;

  // One text request
  typedef struct packed {
    logic [TEXT_W-1:0] text_byte;
    logic              start_new;
  } bss_item_t;

  // One result
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  match_index;
  } bss_rslt_t;

endpackage

`default_nettype wire

@@ rtl/bss_ifs.sv @@
// Valid/ready channel interfaces for text requests and search results.
`default_nettype none

interface bss_in_if;
  logic                      valid;
  logic                      ready;
  logic [bss_pkg::TEXT_W-1:0] text_byte;
  logic                      start_new;

  modport source (output valid, output text_byte, output start_new, input ready);
  modport sink (input valid, input text_byte, input start_new, output ready);
endinterface

interface bss_out_if;
  logic                         valid;
  logic                         ready;
  logic [bss_pkg::STATUS_W-1:0] status;
  logic [bss_pkg::INDEX_W-1:0]  match_index;

  modport source (output valid, output status, output match_index, input ready);
  modport sink (input valid, input status, input match_index, output ready);
endinterface

`default_nettype wire

@@ rtl/bss_cfg.sv @@
// APB-style configuration registers: query bytes, query length and search limit.
`default_nettype none

module bss_cfg #(
  parameter int LIMIT_WIDTH = bss_pkg::LIMIT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bss_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [bss_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bss_pkg::CFG_DATA_W-1:0]   prdata,
  output bss_pkg::bss_cfg_t                cfg
);

  localparam logic [bss_pkg::LIMIT_REG_W-1:0] LIMIT_MASK =
    (LIMIT_WIDTH >= bss_pkg::LIMIT_REG_W) ? {bss_pkg::LIMIT_REG_W{1'b1}} :
    bss_pkg::LIMIT_REG_W'((64'd1 << LIMIT_WIDTH) - 64'd1);

  logic [bss_pkg::CFG_DATA_W-1:0]  qlo_r;
  logic [bss_pkg::CFG_DATA_W-1:0]  qhi_r;
  logic [bss_pkg::QLEN_W-1:0]      qlen_r;
  logic [bss_pkg::LIMIT_REG_W-1:0] limit_r;
  logic [bss_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                            wr_en;

  assign reg_idx = paddr[bss_pkg::CFG_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlo_r   <= '0;
      qhi_r   <= '0;
      qlen_r  <= '0;
      limit_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        bss_pkg::REG_QUERY_LOW:  qlo_r   <= pwdata;
        bss_pkg::REG_QUERY_HIGH: qhi_r   <= pwdata;
        bss_pkg::REG_QUERY_LEN:  qlen_r  <= pwdata[bss_pkg::QLEN_W-1:0];
        bss_pkg::REG_LIMIT:      limit_r <= pwdata[bss_pkg::LIMIT_REG_W-1:0] & LIMIT_MASK;
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      bss_pkg::REG_QUERY_LOW:  prdata = qlo_r;
      bss_pkg::REG_QUERY_HIGH: prdata = qhi_r;
      bss_pkg::REG_QUERY_LEN:  prdata = bss_pkg::CFG_DATA_W'(qlen_r);
      bss_pkg::REG_LIMIT:      prdata = bss_pkg::CFG_DATA_W'(limit_r);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.query = {qhi_r, qlo_r};
  assign cfg.qlen  = qlen_r;
  assign cfg.limit = limit_r;

endmodule

`default_nettype wire

@@ rtl/bss_match.sv @@
// Search state (byte window, position, done flag) and per-byte match evaluation.
`default_nettype none

module bss_match #(
  parameter int QUERY_MAX   = bss_pkg::QUERY_MAX_DEF,
  parameter int LIMIT_WIDTH = bss_pkg::LIMIT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  bss_pkg::bss_item_t item,
  input  bss_pkg::bss_cfg_t  cfg,
  output bss_pkg::bss_rslt_t rslt
);

  localparam int LENW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX + 1) : 1;
  localparam int PW1  = LIMIT_WIDTH + 1;
  localparam int IXW  = (PW1 > bss_pkg::INDEX_W) ? PW1 : bss_pkg::INDEX_W;
  localparam logic [LENW-1:0] LEN_MAX = LENW'(QUERY_MAX);

  logic [bss_pkg::TEXT_W-1:0] win_r   [QUERY_MAX];
  logic [bss_pkg::TEXT_W-1:0] win_nxt [QUERY_MAX];
  logic [bss_pkg::TEXT_W-1:0] w_new   [QUERY_MAX];
  logic [bss_pkg::TEXT_W-1:0] qb      [QUERY_MAX];
  logic [LIMIT_WIDTH-1:0]     pos_r, pos_nxt, pos_eff;
  logic                       done_r, done_nxt, done_eff;
  logic [LENW-1:0]            len;
  logic [QUERY_MAX:0]         hit_by_len;
  logic                       hit;
  logic [IXW-1:0]             pos_inc;
  logic [IXW-1:0]             len_x;
  logic [IXW-1:0]             limit_x;
  logic [IXW-1:0]             idx_x;
  logic [bss_pkg::STATUS_W-1:0] status;
  logic [bss_pkg::INDEX_W-1:0]  match_index;

  // Clamp the query length to the window depth
  always_comb begin
    if (cfg.qlen > bss_pkg::QLEN_W'(QUERY_MAX)) begin
      len = LEN_MAX;
    end else begin
      len = cfg.qlen[LENW-1:0];
    end
  end

  // Start of text clears window and position before the new byte is taken in
  always_comb begin
    done_eff = item.start_new ? 1'b0 : done_r;
    pos_eff  = item.start_new ? '0 : pos_r;
    w_new[0] = item.text_byte;
    for (int k = 1; k < QUERY_MAX; k++) begin
      w_new[k] = item.start_new ? '0 : win_r[k-1];
    end
    for (int j = 0; j < QUERY_MAX; j++) begin
      qb[j] = cfg.query[8*j +: 8];
    end
  end

  // Compare the window against the query for every possible length
  always_comb begin
    hit_by_len[0] = 1'b0;
    for (int l = 1; l <= QUERY_MAX; l++) begin
      hit_by_len[l] = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (qb[j] != w_new[l-1-j]) begin
          hit_by_len[l] = 1'b0;
        end
      end
    end
    hit = hit_by_len[len];
  end

  assign pos_inc = IXW'(pos_eff) + IXW'(1);
  assign len_x   = IXW'(len);
  assign limit_x = IXW'(cfg.limit);
  assign idx_x   = pos_inc - len_x;

  // Decide the outcome of this byte
  always_comb begin
    status      = bss_pkg::ST_SEARCHING;
    match_index = '0;
    if (done_eff) begin
      status = bss_pkg::ST_IDLE;
    end else if (item.text_byte == '0) begin
      status = bss_pkg::ST_NOT_FOUND;
    end else if (len == '0) begin
      status = bss_pkg::ST_FOUND;
    end else if (pos_inc > limit_x) begin
      status = bss_pkg::ST_NOT_FOUND;
    end else if (pos_inc >= len_x && hit) begin
      status      = bss_pkg::ST_FOUND;
      match_index = idx_x[bss_pkg::INDEX_W-1:0];
    end
  end

  // Next state: hold when finished, else shift and advance or finish
  always_comb begin
    if (done_eff) begin
      win_nxt  = win_r;
      pos_nxt  = pos_r;
      done_nxt = 1'b1;
    end else begin
      win_nxt  = w_new;
      done_nxt = (status != bss_pkg::ST_SEARCHING);
      pos_nxt  = (status == bss_pkg::ST_SEARCHING) ? pos_inc[LIMIT_WIDTH-1:0] : pos_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      done_r <= 1'b1;
    end else if (step) begin
      pos_r  <= pos_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      win_r <= win_nxt;
    end
  end

  assign rslt.status      = status;
  assign rslt.match_index = match_index;

endmodule

`default_nettype wire

@@ rtl/bounded_substring_search_core.sv @@
// Top level of the bounded substring search: request/result registers and configuration port.
`default_nettype none

// Streams a text one byte per request and reports, for every byte, whether the
// configured query (up to QUERY_MAX bytes) has been found with its whole match
// inside the first search_limit bytes, whether the search ended without a match
// (zero byte or limit passed), or whether the byte was ignored because no search
// is active. A byte flagged start_new always opens a new search. One result comes
// back per request. Throughput is one request per clock while the result is not
// stalled: a request is held in the input register while the window compare
// evaluates it, and its result is captured in the output register when the
// request advances, which waits while a stalled result occupies that register.
// The window, position and done flag update at that advance as well, which is
// what lets the next byte follow directly. The input stays ready while a result
// waits, as long as the input register itself is free.
// Configuration registers: query low bytes at 0x00, query high bytes at 0x08,
// query length at 0x10, search limit at 0x18; write them only between texts
// with no request in flight.
module bounded_substring_search_core #(
  parameter int QUERY_MAX   = bss_pkg::QUERY_MAX_DEF,
  parameter int LIMIT_WIDTH = bss_pkg::LIMIT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bss_in_if.sink                         in_chan,
  bss_out_if.source                      out_chan,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bss_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bss_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bss_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  bss_pkg::bss_cfg_t  cfg;
  bss_pkg::bss_item_t in_item_r;
  bss_pkg::bss_rslt_t rslt;
  bss_pkg::bss_rslt_t out_rslt_r;
  logic               in_vld_r, in_vld_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic               advance;
  logic               in_ready;
  logic               in_fire;

  assign cfg_pready = 1'b1;

  bss_cfg #(
    .LIMIT_WIDTH (LIMIT_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // Move the held request to the result register when it is free or drains
  assign advance  = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_ready = !in_vld_r || advance;
  assign in_fire  = in_chan.valid && in_ready;

  always_comb begin
    in_vld_nxt = in_ready ? in_chan.valid : in_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Capture request and result payloads
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.text_byte <= in_chan.text_byte;
      in_item_r.start_new <= in_chan.start_new;
    end
    if (advance) begin
      out_rslt_r <= rslt;
    end
  end

  bss_match #(
    .QUERY_MAX   (QUERY_MAX),
    .LIMIT_WIDTH (LIMIT_WIDTH)
  ) u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .rslt  (rslt)
  );

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_vld_r;
  assign out_chan.status      = out_rslt_r.status;
  assign out_chan.match_index = out_rslt_r.match_index;

endmodule

`default_nettype wire

@@ rtl/bss_checker.sv @@
// Port-level checks for the bounded substring search core, bound to the top level.
`default_nettype none

module bss_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bss_pkg::STATUS_W-1:0] status,
  input logic [bss_pkg::INDEX_W-1:0]  match_index
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(match_index))
    else $error("result changed while stalled");

  // Only a found result carries a nonzero index
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != bss_pkg::ST_FOUND |-> match_index == '0)
    else $error("nonzero index without a match");

  // Input backpressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request blocked without a stalled result");

  // A request held back by a stall is taken once the result drains
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready ##1 out_ready |-> in_ready)
    else $error("request stage did not free after drain");

endmodule

bind bounded_substring_search_core bss_checker u_bss_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .status      (out_chan.status),
  .match_index (out_chan.match_index)
);

`default_nettype wire
